>>> hdl/prwqt_pkg.sv
// Shared types and constants of the paired read window quality trimmer.
`default_nettype none
package prwqt_pkg;

  localparam int unsigned QualW      = 7;
  localparam int unsigned RunW       = 8;
  localparam int unsigned WinW       = 8;
  localparam int unsigned LenW       = 14;
  localparam int unsigned TrimW      = 14;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 14;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [QualW-1:0] QualOffset = 7'd33;
  localparam logic [RunW-1:0]  RunMax     = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEFT_THR  = 3'd0,
    REG_RIGHT_THR = 3'd1,
    REG_WINDOW    = 3'd2,
    REG_MIN_LEN   = 3'd3,
    REG_MAX_LEN   = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLASS_BOTH   = 2'd0,
    CLASS_FIRST  = 2'd1,
    CLASS_SECOND = 2'd2,
    CLASS_NONE   = 2'd3
  } pair_class_e;

  // One classified quality character.
  typedef struct packed {
    logic mate;
    logic good_left;
    logic good_right;
    logic last;
  } qual_entry_t;

endpackage
`default_nettype wire

>>> hdl/paired_read_window_quality_trim_top.sv
// A finished pair moves through the snapshot, trim and output registers in turn.
// Throughput: one quality character per cycle; the tracker stalls only while
// the output register is held by out_ready_i and the snapshot stage is full.
// A 4-entry queue sits between the front end and the per-mate run tracker.
// Reset: run state cleared, registers to defaults (window 1, max length 5000).
// Ready is high from reset on; there is no clearing pass.
`default_nettype none
module paired_read_window_quality_trim_top
  import prwqt_pkg::*;
#(
  parameter int unsigned MAX_READ_LENGTH = 8192
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                mate_i,
  input  wire logic [QualW-1:0]    quality_char_i,
  input  wire logic                last_of_read_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               pair_class_o,
  output logic [TrimW-1:0]         first_left_trim_o,
  output logic [TrimW-1:0]         first_right_trim_o,
  output logic [TrimW-1:0]         second_left_trim_o,
  output logic [TrimW-1:0]         second_right_trim_o
);

  logic [QualW-1:0] left_thr_q, right_thr_q;
  logic [WinW-1:0]  window_q;
  logic [LenW-1:0]  min_len_q, max_len_q;

  qual_entry_t push_entry, pop_entry;
  logic        push, full, not_empty, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_thr_q  <= '0;
      right_thr_q <= '0;
      window_q    <= WinW'(1);
      min_len_q   <= '0;
      max_len_q   <= LenW'(5000);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LEFT_THR:  left_thr_q  <= cfg_wdata_i[QualW-1:0];
        REG_RIGHT_THR: right_thr_q <= cfg_wdata_i[QualW-1:0];
        REG_WINDOW:    window_q    <= cfg_wdata_i[WinW-1:0];
        REG_MIN_LEN:   min_len_q   <= cfg_wdata_i[LenW-1:0];
        REG_MAX_LEN:   max_len_q   <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  prwqt_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mate_i         (mate_i),
    .quality_char_i (quality_char_i),
    .last_of_read_i (last_of_read_i),
    .left_thr_i     (left_thr_q),
    .right_thr_i    (right_thr_q),
    .queue_full_i   (full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  prwqt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (push_entry),
    .full_o      (full),
    .not_empty_o (not_empty),
    .pop_i       (pop),
    .entry_o     (pop_entry)
  );

  prwqt_back #(
    .MAX_READ_LENGTH (MAX_READ_LENGTH)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_not_empty_i       (not_empty),
    .q_entry_i           (pop_entry),
    .q_pop_o             (pop),
    .window_i            (window_q),
    .min_len_i           (min_len_q),
    .max_len_i           (max_len_q),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pair_class_o        (pair_class_o),
    .first_left_trim_o   (first_left_trim_o),
    .first_right_trim_o  (first_right_trim_o),
    .second_left_trim_o  (second_left_trim_o),
    .second_right_trim_o (second_right_trim_o)
  );

endmodule
`default_nettype wire

>>> hdl/prwqt_front.sv
// Front end: accepts quality characters and grades them against both cuts.
`default_nettype none
module prwqt_front
  import prwqt_pkg::*;
(
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             mate_i,
  input  wire logic [QualW-1:0] quality_char_i,
  input  wire logic             last_of_read_i,
  input  wire logic [QualW-1:0] left_thr_i,
  input  wire logic [QualW-1:0] right_thr_i,
  input  wire logic             queue_full_i,
  output logic                  push_o,
  output qual_entry_t           entry_o
);

  logic             below_offset;
  logic [QualW-1:0] qual;

  // characters below the offset wrap to a huge quality and pass both cuts
  assign below_offset = quality_char_i < QualOffset;
  assign qual         = quality_char_i - QualOffset;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    entry_o.mate       = mate_i;
    entry_o.good_left  = below_offset || (qual >= left_thr_i);
    entry_o.good_right = below_offset || (qual >= right_thr_i);
    entry_o.last       = last_of_read_i;
  end

endmodule
`default_nettype wire

>>> hdl/prwqt_queue.sv
// Short request queue between the front end and the run tracker.
`default_nettype none
module prwqt_queue
  import prwqt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  qual_entry_t      entry_i,
  output logic             full_o,
  output logic             not_empty_o,
  input  wire logic        pop_i,
  output qual_entry_t      entry_o
);

  qual_entry_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;
  logic                  do_pop;

  assign full_o      = count_q == QueueCntW'(QueueDepth);
  assign not_empty_o = count_q != '0;
  assign entry_o     = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + QueuePtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

>>> hdl/prwqt_back.sv
// Back end: per-mate run tracking, trim computation and length check.
`default_nettype none
module prwqt_back
  import prwqt_pkg::*;
#(
  parameter int unsigned MAX_READ_LENGTH = 8192
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_not_empty_i,
  input  qual_entry_t          q_entry_i,
  output logic                 q_pop_o,
  input  wire logic [WinW-1:0] window_i,
  input  wire logic [LenW-1:0] min_len_i,
  input  wire logic [LenW-1:0] max_len_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           pair_class_o,
  output logic [TrimW-1:0]     first_left_trim_o,
  output logic [TrimW-1:0]     first_right_trim_o,
  output logic [TrimW-1:0]     second_left_trim_o,
  output logic [TrimW-1:0]     second_right_trim_o
);

  localparam int unsigned PW = $clog2(MAX_READ_LENGTH + 1);
  localparam int unsigned KW = ((PW > LenW) ? PW : LenW) + 2;
  localparam logic [PW-1:0] MaxPos = PW'(MAX_READ_LENGTH);

  // per-mate tracking state
  logic [PW-1:0]   pos_q [2], pos_d [2], pos_u [2];
  logic [RunW-1:0] lrun_q[2], lrun_d[2], lrun_u[2];
  logic [RunW-1:0] rrun_q[2], rrun_d[2], rrun_u[2];
  logic            lf_q  [2], lf_d  [2], lf_u  [2];
  logic [PW-1:0]   ls_q  [2], ls_d  [2], ls_u  [2];
  logic            rf_q  [2], rf_d  [2], rf_u  [2];
  logic [PW-1:0]   lre_q [2], lre_d [2], lre_u [2];
  logic            done_q[2], done_d[2], done_u[2];

  // stage 1: snapshot of a finished pair
  logic            s1_vld_q, s1_vld_d;
  logic            s1_wz_q;
  logic [PW-1:0]   s1_len_q[2], s1_ls_q[2], s1_lre_q[2];
  logic            s1_lf_q[2], s1_rf_q[2];
  // stage 2: trims
  logic            s2_vld_q;
  logic [PW-1:0]   s2_len_q[2], s2_lt_q[2], s2_rt_q[2];
  logic [PW-1:0]   lt_c[2], rt_c[2];
  // output register
  logic            out_vld_q;
  logic [1:0]      cls_q;
  logic [TrimW-1:0] trim_q[4];

  logic            pipe_en, pop, m, complete;
  logic [RunW-1:0] lrun_n, rrun_n;
  logic [KW-1:0]   kept[2], lt_x[2], rt_x[2];
  logic            ok[2];
  logic [1:0]      cls_c;

  assign pipe_en = !out_vld_q || out_ready_i;
  assign q_pop_o = pipe_en || !s1_vld_q;
  assign pop     = q_pop_o && q_not_empty_i;
  assign m       = q_entry_i.mate;

  always_comb begin
    pos_u  = pos_q;
    lrun_u = lrun_q;
    rrun_u = rrun_q;
    lf_u   = lf_q;
    ls_u   = ls_q;
    rf_u   = rf_q;
    lre_u  = lre_q;
    done_u = done_q;
    lrun_n = !q_entry_i.good_left ? '0 :
             (lrun_q[m] == RunMax) ? RunMax : lrun_q[m] + RunW'(1);
    rrun_n = !q_entry_i.good_right ? '0 :
             (rrun_q[m] == RunMax) ? RunMax : rrun_q[m] + RunW'(1);
    complete = 1'b0;
    if (pop && !done_q[m]) begin
      if (pos_q[m] < MaxPos) begin
        lrun_u[m] = lrun_n;
        rrun_u[m] = rrun_n;
        if (window_i != '0) begin
          if (!lf_q[m] && lrun_n >= window_i) begin
            lf_u[m] = 1'b1;
            ls_u[m] = pos_q[m] + PW'(1) - PW'(window_i);
          end
          if (rrun_n >= window_i) begin
            rf_u[m]  = 1'b1;
            lre_u[m] = pos_q[m];
          end
        end
        pos_u[m] = pos_q[m] + PW'(1);
      end
      if (q_entry_i.last) begin
        done_u[m] = 1'b1;
        complete  = done_q[!m];
      end
    end
    pos_d  = pos_u;
    lrun_d = lrun_u;
    rrun_d = rrun_u;
    lf_d   = lf_u;
    ls_d   = ls_u;
    rf_d   = rf_u;
    lre_d  = lre_u;
    done_d = done_u;
    if (complete) begin
      for (int i = 0; i < 2; i++) begin
        pos_d[i]  = '0;
        lrun_d[i] = '0;
        rrun_d[i] = '0;
        lf_d[i]   = 1'b0;
        ls_d[i]   = '0;
        rf_d[i]   = 1'b0;
        lre_d[i]  = '0;
        done_d[i] = 1'b0;
      end
    end
    s1_vld_d = s1_vld_q;
    if (pipe_en || !s1_vld_q) begin
      s1_vld_d = complete;
    end
  end

  // trims from the snapshot
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lt_c[i] = s1_wz_q ? '0 : (s1_lf_q[i] ? s1_ls_q[i] : s1_len_q[i]);
      rt_c[i] = s1_wz_q ? '0 :
                (s1_rf_q[i] ? s1_len_q[i] - PW'(1) - s1_lre_q[i] : s1_len_q[i]);
    end
  end

  // kept length check
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lt_x[i] = KW'(s2_lt_q[i]);
      rt_x[i] = KW'(s2_rt_q[i]);
      kept[i] = KW'(s2_len_q[i]) - lt_x[i] - rt_x[i];
      ok[i]   = ($signed(kept[i]) >= $signed(KW'(min_len_i))) &&
                ($signed(kept[i]) <= $signed(KW'(max_len_i)));
    end
    if (ok[0] && ok[1]) begin
      cls_c = CLASS_BOTH;
    end else if (ok[0]) begin
      cls_c = CLASS_FIRST;
    end else if (ok[1]) begin
      cls_c = CLASS_SECOND;
    end else begin
      cls_c = CLASS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        pos_q[i]  <= '0;
        lrun_q[i] <= '0;
        rrun_q[i] <= '0;
        lf_q[i]   <= 1'b0;
        ls_q[i]   <= '0;
        rf_q[i]   <= 1'b0;
        lre_q[i]  <= '0;
        done_q[i] <= 1'b0;
      end
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      lrun_q   <= lrun_d;
      rrun_q   <= rrun_d;
      lf_q     <= lf_d;
      ls_q     <= ls_d;
      rf_q     <= rf_d;
      lre_q    <= lre_d;
      done_q   <= done_d;
      s1_vld_q <= s1_vld_d;
      if (pipe_en) begin
        s2_vld_q  <= s1_vld_q;
        out_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((pipe_en || !s1_vld_q) && complete) begin
      s1_wz_q  <= window_i == '0;
      s1_len_q <= pos_u;
      s1_ls_q  <= ls_u;
      s1_lre_q <= lre_u;
      s1_lf_q  <= lf_u;
      s1_rf_q  <= rf_u;
    end
    if (pipe_en) begin
      s2_len_q  <= s1_len_q;
      s2_lt_q   <= lt_c;
      s2_rt_q   <= rt_c;
      cls_q     <= cls_c;
      trim_q[0] <= ok[0] ? lt_x[0][TrimW-1:0] : '0;
      trim_q[1] <= ok[0] ? rt_x[0][TrimW-1:0] : '0;
      trim_q[2] <= ok[1] ? lt_x[1][TrimW-1:0] : '0;
      trim_q[3] <= ok[1] ? rt_x[1][TrimW-1:0] : '0;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign pair_class_o        = cls_q;
  assign first_left_trim_o   = trim_q[0];
  assign first_right_trim_o  = trim_q[1];
  assign second_left_trim_o  = trim_q[2];
  assign second_right_trim_o = trim_q[3];

  a_never_both_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q[0] && done_q[1]))
    else $error("both mates left done");

  a_clear_on_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete |=> (pos_q[0] == '0) && (pos_q[1] == '0) && !lf_q[0] && !lf_q[1])
    else $error("state not cleared after pair");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q[0] <= MaxPos) && (pos_q[1] <= MaxPos))
    else $error("position past maximum");

  a_left_start_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!lf_q[0] || (ls_q[0] < pos_q[0])) && (!lf_q[1] || (ls_q[1] < pos_q[1])))
    else $error("left start beyond position");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !pipe_en) |-> !pop)
    else $error("pop while snapshot stage blocked");

endmodule
`default_nettype wire
